>>> design/dcr_pkg.sv
package dcr_pkg;

  // Quotient width of both dividers (factor is at most 1.0 in Q1.30).
  localparam int unsigned QW = 31;
  // Fraction bits of the factor.
  localparam int unsigned QBITS = 30;
  // Width that numerator and denominator are normalized into.
  localparam int unsigned NW = 33;
  // Width of the exact squared distance sums.
  localparam int unsigned SQW = 66;
  // Width of the mass sum.
  localparam int unsigned WW = 25;
  // Width of the mass-weighted factor product.
  localparam int unsigned PW = 55;

  typedef struct packed {
    logic signed [31:0] pos_ax;
    logic signed [31:0] pos_ay;
    logic signed [31:0] pos_bx;
    logic signed [31:0] pos_by;
    logic [23:0]        inv_mass_a;
    logic [23:0]        inv_mass_b;
    logic [30:0]        rest_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_ax;
    logic signed [31:0] new_ay;
    logic signed [31:0] new_bx;
    logic signed [31:0] new_by;
    logic               skipped;
  } out_t;

  // Per-item context that rides along the whole pipeline.
  typedef struct packed {
    logic signed [31:0] pos_ax;
    logic signed [31:0] pos_ay;
    logic signed [31:0] pos_bx;
    logic signed [31:0] pos_by;
    logic [NW-1:0]      mag_x;
    logic [NW-1:0]      mag_y;
    logic               neg_x;
    logic               neg_y;
    logic               q_neg;
    logic               skip;
    logic [23:0]        wa;
    logic [23:0]        wb;
    logic [WW-1:0]      wsum;
  } side_t;

endpackage

>>> design/dcr_front.sv
module dcr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  dcr_pkg::in_t        data_i,
  output logic                valid_o,
  output dcr_pkg::side_t      side_o,
  output logic [dcr_pkg::NW-1:0] num_o,
  output logic [dcr_pkg::NW-1:0] den_o
);
  import dcr_pkg::*;

  logic signed [32:0] dx, dy;
  side_t              side1_d;
  logic [4:0]         v_q;
  side_t              side1_q, side2_q, side3_q, side4_q, side5_q;
  side_t              side3_d;
  logic [30:0]        r1_q;
  logic [SQW-1:0]     sqx_q, sqy_q;
  logic [61:0]        r2_q;
  logic [SQW-1:0]     d2, den3_d, num3_d;
  logic               ge3;
  logic [SQW-1:0]     num3_q, den3_q, num4_q, den4_q;
  logic [5:0]         sh4_d, sh4_q;
  logic [SQW-1:0]     num5_d, den5_d;
  logic [NW-1:0]      num5_q, den5_q;

  // Stage 1: coordinate differences and their magnitudes.
  always_comb begin
    dx = {data_i.pos_bx[31], data_i.pos_bx} - {data_i.pos_ax[31], data_i.pos_ax};
    dy = {data_i.pos_by[31], data_i.pos_by} - {data_i.pos_ay[31], data_i.pos_ay};
    side1_d.pos_ax = data_i.pos_ax;
    side1_d.pos_ay = data_i.pos_ay;
    side1_d.pos_bx = data_i.pos_bx;
    side1_d.pos_by = data_i.pos_by;
    side1_d.neg_x  = dx[32];
    side1_d.neg_y  = dy[32];
    side1_d.mag_x  = dx[32] ? (~dx + 33'd1) : dx;
    side1_d.mag_y  = dy[32] ? (~dy + 33'd1) : dy;
    side1_d.q_neg  = 1'b0;
    side1_d.skip   = 1'b0;
    side1_d.wa     = data_i.inv_mass_a;
    side1_d.wb     = data_i.inv_mass_b;
    side1_d.wsum   = {1'b0, data_i.inv_mass_a} + {1'b0, data_i.inv_mass_b};
  end

  // Stage 3: squared distance, numerator magnitude and sign, denominator and skip flag.
  always_comb begin
    d2     = sqx_q + sqy_q;
    den3_d = d2 + SQW'(r2_q);
    ge3    = d2 >= SQW'(r2_q);
    num3_d = ge3 ? (d2 - SQW'(r2_q)) : (SQW'(r2_q) - d2);
    side3_d       = side2_q;
    side3_d.q_neg = !ge3;
    side3_d.skip  = (side2_q.wsum == '0) || (den3_d == '0);
  end

  // Stage 4: shift that brings the denominator below the normalize limit.
  always_comb begin
    sh4_d = '0;
    for (int i = NW; i < SQW; i++) begin
      if (den3_q[i]) begin
        sh4_d = 6'(i - NW + 1);
      end
    end
  end

  // Stage 5: shift both operands together.
  always_comb begin
    num5_d = num4_q >> sh4_q;
    den5_d = den4_q >> sh4_q;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side1_d;
      r1_q    <= data_i.rest_length;

      side2_q <= side1_q;
      sqx_q   <= SQW'(side1_q.mag_x) * SQW'(side1_q.mag_x);
      sqy_q   <= SQW'(side1_q.mag_y) * SQW'(side1_q.mag_y);
      r2_q    <= 62'(r1_q) * 62'(r1_q);

      side3_q <= side3_d;
      num3_q  <= num3_d;
      den3_q  <= den3_d;

      side4_q <= side3_q;
      num4_q  <= num3_q;
      den4_q  <= den3_q;
      sh4_q   <= sh4_d;

      side5_q <= side4_q;
      num5_q  <= num5_d[NW-1:0];
      den5_q  <= den5_d[NW-1:0];
    end
  end

  assign valid_o = v_q[4];
  assign side_o  = side5_q;
  assign num_o   = num5_q;
  assign den_o   = den5_q;

endmodule

>>> design/dcr_qdiv.sv
module dcr_qdiv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dcr_pkg::side_t         side_i,
  input  logic [dcr_pkg::NW-1:0] num_i,
  input  logic [dcr_pkg::NW-1:0] den_i,
  output logic                   valid_o,
  output dcr_pkg::side_t         side_o,
  output logic [dcr_pkg::QW-1:0] quo_o
);
  import dcr_pkg::*;

  logic          v_q    [QW];
  side_t         side_q [QW];
  logic [NW-1:0] rem_q  [QW];
  logic [NW-1:0] den_q  [QW];
  logic [QW-1:0] quo_q  [QW];

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          v_in;
    side_t         side_in;
    logic [NW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign trial   = {1'b0, num_i};
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign trial   = {rem_q[k-1], 1'b0};
    end

    assign diff = trial - {1'b0, den_in};
    assign take = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
        den_q[k]  <= den_in;
        rem_q[k]  <= take ? diff[NW-1:0] : trial[NW-1:0];
        quo_q[k]  <= {quo_in[QW-2:0], take};
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign quo_o   = quo_q[QW-1];

endmodule

>>> design/dcr_gdiv.sv
module dcr_gdiv (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dcr_pkg::side_t         side_i,
  input  logic [dcr_pkg::QW-1:0] quo_i,
  output logic                   valid_o,
  output dcr_pkg::side_t         side_o,
  output logic [dcr_pkg::QW-1:0] ga_o,
  output logic [dcr_pkg::QW-1:0] gb_o
);
  import dcr_pkg::*;

  logic          vm_q;
  side_t         sidem_q;
  logic [PW-1:0] prodm_q [2];
  logic          v_q     [QW];
  side_t         side_q  [QW];
  logic [PW-1:0] prod_q  [QW][2];
  logic [WW-1:0] rem_q   [QW][2];
  logic [QW-1:0] quo_q   [QW][2];

  // Weighted factor products, one per particle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sidem_q    <= side_i;
      prodm_q[0] <= PW'(quo_i) * PW'(side_i.wa);
      prodm_q[1] <= PW'(quo_i) * PW'(side_i.wb);
    end
  end

  // Division by the mass sum, one quotient bit per stage for both lanes.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic  v_in;
    side_t side_in;

    if (k == 0) begin : g_first
      assign v_in    = vm_q;
      assign side_in = sidem_q;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [PW-1:0] prod_in;
      logic [QW-1:0] quo_in;
      logic [WW:0]   trial;
      logic [WW:0]   diff;
      logic          take;

      if (k == 0) begin : g_first
        assign prod_in = prodm_q[l];
        assign quo_in  = '0;
        assign trial   = {1'b0, prodm_q[l][PW-1:QBITS]};
      end else begin : g_next
        assign prod_in = prod_q[k-1][l];
        assign quo_in  = quo_q[k-1][l];
        assign trial   = {rem_q[k-1][l], prod_q[k-1][l][QW-1-k]};
      end

      assign diff = trial - {1'b0, side_in.wsum};
      assign take = trial >= {1'b0, side_in.wsum};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[k][l] <= prod_in;
          rem_q[k][l]  <= take ? diff[WW-1:0] : trial[WW-1:0];
          quo_q[k][l]  <= {quo_in[QW-2:0], take};
        end
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign side_o  = side_q[QW-1];
  assign ga_o    = quo_q[QW-1][0];
  assign gb_o    = quo_q[QW-1][1];

endmodule

>>> design/dcr_back.sv
module dcr_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  dcr_pkg::side_t         side_i,
  input  logic [dcr_pkg::QW-1:0] ga_i,
  input  logic [dcr_pkg::QW-1:0] gb_i,
  output logic                   valid_o,
  output dcr_pkg::out_t          data_o
);
  import dcr_pkg::*;

  localparam int unsigned MW = NW + QW;

  logic [1:0]    v_q;
  side_t         side1_q;
  logic [MW-1:0] pax, pay, pbx, pby;
  logic [NW-1:0] max_q, may_q, mbx_q, mby_q;
  out_t          res_d, res_q;
  logic          neg_ax, neg_ay;

  // Adds a signed move to a position and clamps to the 32-bit range.
  function automatic logic signed [31:0] apply(input logic signed [31:0] p,
                                               input logic [NW-1:0] mag,
                                               input logic negate);
    logic signed [NW+1:0] m;
    logic signed [NW+1:0] s;
    m = negate ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    s = {{(NW-30){p[31]}}, p} + m;
    if (s[NW+1:31] == '0 || s[NW+1:31] == '1) begin
      apply = s[31:0];
    end else if (s[NW+1]) begin
      apply = 32'sh8000_0000;
    end else begin
      apply = 32'sh7FFF_FFFF;
    end
  endfunction

  // Stage 1: per-axis moves.
  assign pax = MW'(side_i.mag_x) * MW'(ga_i);
  assign pay = MW'(side_i.mag_y) * MW'(ga_i);
  assign pbx = MW'(side_i.mag_x) * MW'(gb_i);
  assign pby = MW'(side_i.mag_y) * MW'(gb_i);

  // Stage 2: signed update with saturation, or pass-through when skipped.
  always_comb begin
    neg_ax = side1_q.q_neg != side1_q.neg_x;
    neg_ay = side1_q.q_neg != side1_q.neg_y;
    if (side1_q.skip) begin
      res_d.new_ax = side1_q.pos_ax;
      res_d.new_ay = side1_q.pos_ay;
      res_d.new_bx = side1_q.pos_bx;
      res_d.new_by = side1_q.pos_by;
    end else begin
      res_d.new_ax = apply(side1_q.pos_ax, max_q, neg_ax);
      res_d.new_ay = apply(side1_q.pos_ay, may_q, neg_ay);
      res_d.new_bx = apply(side1_q.pos_bx, mbx_q, !neg_ax);
      res_d.new_by = apply(side1_q.pos_by, mby_q, !neg_ay);
    end
    res_d.skipped = side1_q.skip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      max_q   <= pax[MW-2:QBITS];
      may_q   <= pay[MW-2:QBITS];
      mbx_q   <= pbx[MW-2:QBITS];
      mby_q   <= pby[MW-2:QBITS];
      res_q   <= res_d;
    end
  end

  assign valid_o = v_q[1];
  assign data_o  = res_q;

endmodule

>>> design/distance_constraint_relax_core.sv
// Distance constraint relaxation, one step without square root.
// Input channel: in_valid_i / in_ready_o with in_data_i holding two particle
// positions, their inverse masses and the rest length. Output channel:
// out_valid_o / out_ready_i with out_data_o holding the corrected positions
// and the skipped flag.
// Throughput: one item per cycle while the skid register is empty. Every
// stage is a register, including one stage per quotient bit in the factor
// divider and in the mass divider. The path from acceptance to out_valid_o
// runs through 5 front-end stages, 31 factor-divider stages, 32 mass stages,
// 2 back-end stages and the output register.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register. Only while the skid register is full does
// the pipeline freeze and in_ready_o drop; nothing is lost or repeated.
module distance_constraint_relax_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dcr_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dcr_pkg::out_t  out_data_o
);
  import dcr_pkg::*;

  logic          en;
  logic          fr_valid, qd_valid, gd_valid, bk_valid;
  side_t         fr_side, qd_side, gd_side;
  logic [NW-1:0] fr_num, fr_den;
  logic [QW-1:0] qd_quo, gd_ga, gd_gb;
  out_t          bk_data;
  logic          out_valid_q, skid_valid_q;
  out_t          out_q, skid_q;

  // Pipeline advances whenever the skid register is free.
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  dcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .side_o  (fr_side),
    .num_o   (fr_num),
    .den_o   (fr_den)
  );

  dcr_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .num_i   (fr_num),
    .den_i   (fr_den),
    .valid_o (qd_valid),
    .side_o  (qd_side),
    .quo_o   (qd_quo)
  );

  dcr_gdiv u_gdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (qd_valid),
    .side_i  (qd_side),
    .quo_i   (qd_quo),
    .valid_o (gd_valid),
    .side_o  (gd_side),
    .ga_o    (gd_ga),
    .gb_o    (gd_gb)
  );

  dcr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (gd_valid),
    .side_i  (gd_side),
    .ga_i    (gd_ga),
    .gb_i    (gd_gb),
    .valid_o (bk_valid),
    .data_o  (bk_data)
  );

  // Output register with a one-item skid register behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= en && bk_valid;
      end
    end else if (en && bk_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (en && bk_valid) begin
        out_q <= bk_data;
      end
    end else if (en && bk_valid) begin
      skid_q <= bk_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
